// ----- rtl/remote_address_table_assert.svh -----
// assertion macros shared by the remote address table rtl
// expects i_clk and i_rst_n in the scope where they are used
`ifndef REMOTE_ADDRESS_TABLE_ASSERT_SVH
`define REMOTE_ADDRESS_TABLE_ASSERT_SVH

// same-cycle implication
`define RAT_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("remote address table: same-cycle check failed");

// next-cycle implication
`define RAT_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("remote address table: next-cycle check failed");

`endif

// ----- rtl/rat_pkg.sv -----
// types and codes for the remote address table
// no dependencies
package rat_pkg;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_MARK   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req_type;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    typedef struct packed {
        t_req_type   req_type;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] port_num;
        logic [7:0]  remote_id;
        logic [3:0]  local_id;
    } t_req;

    // priority chain passed from lower to higher slots
    typedef struct packed {
        logic id_seen;
        logic addr_seen;
        logic free_seen;
    } t_chain;

    typedef struct packed {
        logic      commit;
        t_req_type op;
        logic      any_id;
        logic      mark_en;
        logic [2:0] mark_bit;
    } t_cmd;

    typedef struct packed {
        logic sel;
        logic changed;
        logic valid;
        logic valid_next;
    } t_cell_out;

endpackage

// ----- rtl/rat_cell.sv -----
// one slot of the remote address table: entry storage, compare and update
// depends on rat_pkg
module rat_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmp,
    input  rat_pkg::t_req      i_req,
    input  rat_pkg::t_cmd      i_cmd,
    input  rat_pkg::t_chain    i_chain,
    output rat_pkg::t_chain    o_chain,
    output rat_pkg::t_cell_out o_out
);
    import rat_pkg::*;

    logic        r_valid;
    logic [63:0] r_addr_hi;
    logic [63:0] r_addr_lo;
    logic [15:0] r_port;
    logic [7:0]  r_id;
    logic [7:0]  r_flags;
    logic [7:0]  r_retry;
    logic        r_id_hit;
    logic        r_addr_hit;
    logic        r_exact;

    logic n_valid;
    logic first_id;
    logic first_addr;
    logic first_free;
    logic sel;
    logic fill;
    logic update;
    logic drop;
    logic mark;

    always_comb begin
        first_id   = r_id_hit & ~i_chain.id_seen;
        first_addr = r_addr_hit & ~i_chain.addr_seen;
        first_free = ~r_valid & ~i_chain.free_seen;

        o_chain.id_seen   = i_chain.id_seen | r_id_hit;
        o_chain.addr_seen = i_chain.addr_seen | r_addr_hit;
        o_chain.free_seen = i_chain.free_seen | ~r_valid;

        sel    = 1'b0;
        fill   = 1'b0;
        update = 1'b0;
        drop   = 1'b0;
        mark   = 1'b0;
        case (i_cmd.op)
            REQ_ADD: begin
                if (i_cmd.any_id) begin
                    sel    = first_id;
                    update = first_id & ~r_exact;
                end else begin
                    sel  = first_free;
                    fill = first_free;
                end
            end
            REQ_REMOVE: begin
                sel  = first_id;
                drop = first_id;
            end
            REQ_MARK: begin
                sel  = first_addr;
                mark = first_addr & i_cmd.mark_en;
            end
            default: begin
            end
        endcase

        n_valid = fill ? 1'b1 : (drop ? 1'b0 : r_valid);

        o_out.sel        = sel;
        o_out.changed    = fill | update;
        o_out.valid      = r_valid;
        o_out.valid_next = n_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp) begin
            r_id_hit   <= r_valid && (r_id == i_req.remote_id);
            r_addr_hit <= r_valid && (r_addr_hi == i_req.addr_hi) && (r_addr_lo == i_req.addr_lo);
            r_exact    <= (r_addr_hi == i_req.addr_hi) && (r_addr_lo == i_req.addr_lo)
                          && (r_port == i_req.port_num);
        end
        if (i_cmd.commit) begin
            if (fill || update) begin
                r_addr_hi <= i_req.addr_hi;
                r_addr_lo <= i_req.addr_lo;
                r_port    <= i_req.port_num;
            end
            if (fill) begin
                r_id    <= i_req.remote_id;
                r_flags <= 8'd0;
                r_retry <= 8'd0;
            end else if (mark) begin
                r_flags <= r_flags | (8'd1 << i_cmd.mark_bit);
            end else begin
                r_retry <= r_retry;
            end
        end
    end

endmodule

// ----- rtl/remote_address_table.sv -----
// remote address table: a new item is accepted only while idle or as the last one commits
// the S_CMP state registers the id and address compares in every slot cell, and S_APPLY
// resolves the lowest matching or free slot along the cell chain and commits the update
// a waiting result that is not taken holds the commit and stalls the input until it is taken
// reset clears the valid mask, the received flag and the handshake state; slot contents
// are not cleared and are only read while their valid bit is set
`include "remote_address_table_assert.svh"

module remote_address_table #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic [15:0] i_port_num,
    input  logic [7:0]  i_remote_id,
    input  logic [3:0]  i_local_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot_index,
    output logic [7:0]  o_valid_bits,
    output logic        o_list_received
);
    import rat_pkg::*;

    localparam int MaskW = (NUM_SLOTS > 8) ? NUM_SLOTS : 8;

    t_state r_state;
    t_state n_state;
    t_req   r_req;
    logic   r_received;
    logic   n_received;
    logic   r_out_valid;
    logic [1:0] r_status;
    logic [2:0] r_slot;
    logic [7:0] r_vbits;
    logic       r_lrx;

    logic w_accept;
    logic w_out_free;
    logic w_cmp;
    logic w_commit;
    t_cmd w_cmd;
    logic [1:0] w_status;
    logic [2:0] w_slot;
    logic [MaskW-1:0] w_mask_ext;

    t_chain    w_chain [NUM_SLOTS+1];
    t_cell_out w_cell  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] w_sel;
    logic [NUM_SLOTS-1:0] w_changed;
    logic [NUM_SLOTS-1:0] w_valid_now;
    logic [NUM_SLOTS-1:0] w_valid_next;

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = ~((r_state == S_IDLE) || ((r_state == S_APPLY) && w_out_free));
    assign w_accept   = i_in_valid & ~o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = w_accept ? S_CMP : S_IDLE;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = w_accept ? S_CMP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_cmp    = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            S_IDLE:  begin
            end
            S_CMP:   w_cmp = 1'b1;
            S_APPLY: w_commit = w_out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        int lid;
        lid = int'(r_req.local_id);
        w_cmd.commit   = w_commit;
        w_cmd.op       = r_req.req_type;
        w_cmd.any_id   = w_chain[NUM_SLOTS].id_seen;
        w_cmd.mark_en  = (lid >= NUM_SLOTS) && ((lid - NUM_SLOTS) < 8);
        w_cmd.mark_bit = 3'(lid - NUM_SLOTS);
    end

    assign w_chain[0] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        rat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmp   (w_cmp),
            .i_req   (r_req),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_out   (w_cell[g])
        );
    end

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_sel[i]        = w_cell[i].sel;
            w_changed[i]    = w_cell[i].changed;
            w_valid_now[i]  = w_cell[i].valid;
            w_valid_next[i] = w_cell[i].valid_next;
        end
        w_slot = 3'd0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_slot = w_slot | (w_sel[i] ? 3'(i) : 3'd0);
        end
        w_mask_ext = MaskW'(w_valid_next);
    end

    always_comb begin
        w_status   = STATUS_OK;
        n_received = r_received;
        case (r_req.req_type)
            REQ_ADD: begin
                if (!w_chain[NUM_SLOTS].id_seen && !w_chain[NUM_SLOTS].free_seen) begin
                    w_status = STATUS_FULL;
                end
                if (|w_changed) begin
                    n_received = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (!w_chain[NUM_SLOTS].id_seen) begin
                    w_status = STATUS_NO_MATCH;
                end
            end
            REQ_MARK: begin
                if (!w_chain[NUM_SLOTS].addr_seen) begin
                    w_status = STATUS_NO_MATCH;
                end
            end
            default: n_received = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_received  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_received  <= n_received;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.req_type  <= t_req_type'(i_req_type);
            r_req.addr_hi   <= i_addr_hi;
            r_req.addr_lo   <= i_addr_lo;
            r_req.port_num  <= i_port_num;
            r_req.remote_id <= i_remote_id;
            r_req.local_id  <= i_local_id;
        end
        if (w_commit) begin
            r_status <= w_status;
            r_slot   <= w_slot;
            r_vbits  <= w_mask_ext[7:0];
            r_lrx    <= n_received;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_slot_index    = r_slot;
    assign o_valid_bits    = r_vbits;
    assign o_list_received = r_lrx;

    `RAT_ASSERT_IMP(a_sel_onehot, r_state == S_APPLY, $onehot0(w_sel))
    `RAT_ASSERT_IMP(a_accept_state, w_accept, (r_state == S_IDLE) || (r_state == S_APPLY))
    `RAT_ASSERT_NEXT(a_accept_cmp, w_accept, r_state == S_CMP)
    `RAT_ASSERT_NEXT(a_commit_out, w_commit, o_out_valid)
    `RAT_ASSERT_IMP(a_full_mask, w_commit && (w_status == STATUS_FULL), &w_valid_now)

endmodule
